>>> hw/rtl/cdq_pkg.sv
// ----------------------------------------------------------------------------
// cdq_pkg
// Shared types, constants and pointer helpers for the circular deque.
// ----------------------------------------------------------------------------
package cdq_pkg;

  localparam int DEPTH   = 1024;
  localparam int PTR_W   = $clog2(DEPTH);
  localparam int VAL_W   = 32;
  localparam int CMD_W   = 3;
  localparam int CNT_W   = 10;
  localparam int IN_W    = 40;
  localparam int OUT_W   = 112;

  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [VAL_W-1:0] NONE_VAL = '1;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_QUERY      = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_LOAD
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic exec;   // apply the command in the input word
    logic rd;     // read front and back slots
    logic load;   // fill the output register
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
  } dp_stat_t;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    ptr_next = (p == PTR_LAST) ? '0 : p + PTR_W'(1);
  endfunction

  function automatic logic [PTR_W-1:0] ptr_prev(input logic [PTR_W-1:0] p);
    ptr_prev = (p == '0) ? PTR_LAST : p - PTR_W'(1);
  endfunction

endpackage

>>> hw/rtl/circular_deque_unit.sv
// ----------------------------------------------------------------------------
// circular_deque_unit
// Double-ended queue in a ring of slots with push/pop at both ends.
// ----------------------------------------------------------------------------
// each word is applied, its front/back slots are read, then the output register is loaded
// one word is in flight at a time; set by the single-command sequencer
// and the registered read of the slot memory
// a new word is taken while the previous result still waits at the output
// reset: synchronous active-low rst_n empties the deque, slot contents kept
module circular_deque_unit (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [cdq_pkg::IN_W-1:0]  in_tdata,   // cmd[2:0], push_value[34:3], pad
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [cdq_pkg::OUT_W-1:0] out_tdata   // popped_value[31:0], failed[32],
                                                // item_count[42:33], is_empty[43],
                                                // front_value[75:44],
                                                // back_value[107:76], pad
);

  cdq_pkg::ctrl_cmd_t cmd;
  cdq_pkg::dp_stat_t  stat;

  cdq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  cdq_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

`ifndef NO_ASSERTIONS
  a_one_step: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.exec, cmd.rd, cmd.load}))
    else $error("more than one sequencer step active");

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |-> cmd.exec)
    else $error("accepted word not applied");

  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> out_tvalid)
    else $error("loaded result not presented");

  a_empty_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[43]) |->
      (out_tdata[42:33] == 10'd0 && out_tdata[75:44] == 32'hFFFF_FFFF &&
       out_tdata[107:76] == 32'hFFFF_FFFF))
    else $error("empty result with stale count or end values");
`endif

endmodule

>>> hw/rtl/cdq_ctrl.sv
// ----------------------------------------------------------------------------
// cdq_ctrl
// Sequencer: apply command, read front/back slots, load the output register.
// ----------------------------------------------------------------------------
module cdq_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  cdq_pkg::dp_stat_t  stat,
  output cdq_pkg::ctrl_cmd_t cmd
);

  cdq_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cdq_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    cmd       = '0;
    case (state_r)
      cdq_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.exec  = 1'b1;
          state_nxt = cdq_pkg::ST_READ;
        end
      end
      cdq_pkg::ST_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = cdq_pkg::ST_LOAD;
      end
      cdq_pkg::ST_LOAD: begin
        // hold until the previous result has been taken
        if (stat.out_free) begin
          cmd.load  = 1'b1;
          state_nxt = cdq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = cdq_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

>>> hw/rtl/cdq_dpath.sv
// ----------------------------------------------------------------------------
// cdq_dpath
// Slot memory, ring pointers, item count and the output register.
// ----------------------------------------------------------------------------
module cdq_dpath (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [cdq_pkg::IN_W-1:0]   in_tdata,
  input  cdq_pkg::ctrl_cmd_t         cmd,
  output cdq_pkg::dp_stat_t          stat,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [cdq_pkg::OUT_W-1:0]  out_tdata
);

  logic [cdq_pkg::VAL_W-1:0] slots [cdq_pkg::DEPTH];

  logic [cdq_pkg::PTR_W-1:0] head_r, tail_r, count_r;
  logic [cdq_pkg::PTR_W-1:0] head_nxt, tail_nxt, count_nxt;
  logic [cdq_pkg::VAL_W-1:0] front_r, back_r;     // cached ends of the last result
  logic [cdq_pkg::VAL_W-1:0] rd_front_r, rd_back_r;
  logic [cdq_pkg::VAL_W-1:0] popped_r, popped_nxt;
  logic                      failed_r, failed_nxt;
  logic                      out_valid_r;
  logic [cdq_pkg::OUT_W-1:0] out_data_r;

  logic [cdq_pkg::CMD_W-1:0] in_cmd;
  logic [cdq_pkg::VAL_W-1:0] in_val;
  logic                      empty, full;
  logic                      wr_en;
  logic [cdq_pkg::PTR_W-1:0] wr_addr;
  logic                      res_empty;
  logic [cdq_pkg::VAL_W-1:0] res_front, res_back;

  assign in_cmd = in_tdata[cdq_pkg::CMD_W-1:0];
  assign in_val = in_tdata[cdq_pkg::CMD_W +: cdq_pkg::VAL_W];
  assign empty  = (count_r == '0);
  assign full   = (count_r == cdq_pkg::PTR_LAST);

  always_comb begin
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    count_nxt  = count_r;
    popped_nxt = cdq_pkg::NONE_VAL;
    failed_nxt = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = head_r;
    case (in_cmd)
      cdq_pkg::CMD_PUSH_FRONT: begin
        if (full) begin
          failed_nxt = 1'b1;
        end else begin
          wr_en     = 1'b1;
          wr_addr   = head_r;
          head_nxt  = cdq_pkg::ptr_prev(head_r);
          count_nxt = count_r + cdq_pkg::PTR_W'(1);
        end
      end
      cdq_pkg::CMD_PUSH_BACK: begin
        if (full) begin
          failed_nxt = 1'b1;
        end else begin
          wr_en     = 1'b1;
          wr_addr   = cdq_pkg::ptr_next(tail_r);
          tail_nxt  = cdq_pkg::ptr_next(tail_r);
          count_nxt = count_r + cdq_pkg::PTR_W'(1);
        end
      end
      cdq_pkg::CMD_POP_FRONT: begin
        if (empty) begin
          failed_nxt = 1'b1;
        end else begin
          popped_nxt = front_r;
          head_nxt   = cdq_pkg::ptr_next(head_r);
          count_nxt  = count_r - cdq_pkg::PTR_W'(1);
        end
      end
      cdq_pkg::CMD_POP_BACK: begin
        if (empty) begin
          failed_nxt = 1'b1;
        end else begin
          popped_nxt = back_r;
          tail_nxt   = cdq_pkg::ptr_prev(tail_r);
          count_nxt  = count_r - cdq_pkg::PTR_W'(1);
        end
      end
      default: begin
        // query and unused codes leave the state alone
      end
    endcase
  end

  // slot memory: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (cmd.exec && wr_en) begin
      slots[wr_addr] <= in_val;
    end
    if (cmd.rd) begin
      rd_front_r <= slots[cdq_pkg::ptr_next(head_r)];
      rd_back_r  <= slots[tail_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else if (cmd.exec) begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      popped_r <= popped_nxt;
      failed_r <= failed_nxt;
    end
    if (cmd.load) begin
      front_r <= rd_front_r;
      back_r  <= rd_back_r;
    end
  end

  assign res_empty = (count_r == '0);
  assign res_front = res_empty ? cdq_pkg::NONE_VAL : rd_front_r;
  assign res_back  = res_empty ? cdq_pkg::NONE_VAL : rd_back_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_data_r <= {4'b0, res_back, res_front, res_empty,
                     cdq_pkg::CNT_W'(count_r), failed_r, popped_r};
    end
  end

  assign stat.out_free = !out_valid_r || out_tready;
  assign out_tvalid    = out_valid_r;
  assign out_tdata     = out_data_r;

endmodule

>>> test/tb_circular_deque_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_circular_deque_unit
// Self-checking bench for the ring-buffer deque. Commands go in as stream
// words and each one is mirrored in a behavioral deque inside a scoreboard.
// Every result word is checked field by field against that deque. The random
// part fills the ring up to capacity, hammers it while full and drains it
// again, under varying backpressure on both channels.
// ----------------------------------------------------------------------------
module tb_circular_deque_unit;

  localparam int CAPACITY    = cdq_pkg::DEPTH - 1;
  localparam int STALL_LIMIT = 2000;

  typedef struct {
    logic [cdq_pkg::VAL_W-1:0] popped;
    logic                      failed;
    logic [cdq_pkg::CNT_W-1:0] count;
    logic                      empty;
    logic [cdq_pkg::VAL_W-1:0] front;
    logic [cdq_pkg::VAL_W-1:0] back;
  } deque_result_t;

  class deque_scoreboard;
    logic [cdq_pkg::VAL_W-1:0] slot_mem [cdq_pkg::DEPTH];
    int unsigned               head_ptr;
    int unsigned               tail_ptr;
    deque_result_t             expected_q[$];
    int                        errors;
    int                        n_checked;

    function new();
      head_ptr  = 0;
      tail_ptr  = 0;
      errors    = 0;
      n_checked = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    task report_mismatch(string msg);
      $display("[%0t] result %0d: %s", $realtime, n_checked, msg);
      errors++;
    endtask

    // head_ptr is the free slot before the front item, tail_ptr the back item
    function void note_word(logic [cdq_pkg::CMD_W-1:0] cmd_bits,
                            logic [cdq_pkg::VAL_W-1:0] value);
      cdq_pkg::cmd_t op;
      deque_result_t r;
      logic          is_full;
      logic          is_empty;
      op       = cdq_pkg::cmd_t'(cmd_bits);
      is_full  = ((tail_ptr + 1) % cdq_pkg::DEPTH) == head_ptr;
      is_empty = head_ptr == tail_ptr;
      r.popped = cdq_pkg::NONE_VAL;
      r.failed = 1'b0;
      case (op)
        cdq_pkg::CMD_PUSH_FRONT: begin
          if (is_full) begin
            r.failed = 1'b1;
          end else begin
            slot_mem[head_ptr] = value;
            head_ptr = (head_ptr + cdq_pkg::DEPTH - 1) % cdq_pkg::DEPTH;
          end
        end
        cdq_pkg::CMD_PUSH_BACK: begin
          if (is_full) begin
            r.failed = 1'b1;
          end else begin
            tail_ptr = (tail_ptr + 1) % cdq_pkg::DEPTH;
            slot_mem[tail_ptr] = value;
          end
        end
        cdq_pkg::CMD_POP_FRONT: begin
          if (is_empty) begin
            r.failed = 1'b1;
          end else begin
            head_ptr = (head_ptr + 1) % cdq_pkg::DEPTH;
            r.popped = slot_mem[head_ptr];
          end
        end
        cdq_pkg::CMD_POP_BACK: begin
          if (is_empty) begin
            r.failed = 1'b1;
          end else begin
            r.popped = slot_mem[tail_ptr];
            tail_ptr = (tail_ptr + cdq_pkg::DEPTH - 1) % cdq_pkg::DEPTH;
          end
        end
        default: ;  // query and the unused codes leave the state alone
      endcase
      r.empty = head_ptr == tail_ptr;
      r.count = cdq_pkg::CNT_W'((tail_ptr + cdq_pkg::DEPTH - head_ptr) % cdq_pkg::DEPTH);
      r.front = r.empty ? cdq_pkg::NONE_VAL : slot_mem[(head_ptr + 1) % cdq_pkg::DEPTH];
      r.back  = r.empty ? cdq_pkg::NONE_VAL : slot_mem[tail_ptr];
      expected_q.insert(expected_q.size(), r);
    endfunction

    task compare_field(string name, logic [cdq_pkg::VAL_W-1:0] got,
                       logic [cdq_pkg::VAL_W-1:0] want);
      if (got !== want)
        report_mismatch($sformatf("%s got %h expected %h", name, got, want));
    endtask

    task check_word(logic [cdq_pkg::OUT_W-1:0] word);
      deque_result_t want;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result word %h", word));
      end else begin
        want = expected_q[0];
        expected_q.delete(0);
        compare_field("popped_value", word[31:0], want.popped);
        compare_field("failed", cdq_pkg::VAL_W'(word[32]), cdq_pkg::VAL_W'(want.failed));
        compare_field("item_count", cdq_pkg::VAL_W'(word[42:33]),
                      cdq_pkg::VAL_W'(want.count));
        compare_field("is_empty", cdq_pkg::VAL_W'(word[43]), cdq_pkg::VAL_W'(want.empty));
        compare_field("front_value", word[75:44], want.front);
        compare_field("back_value", word[107:76], want.back);
      end
      n_checked++;
    endtask
  endclass

  logic                      clk;
  logic                      rst_n      = 1'b0;
  logic                      in_tvalid  = 1'b0;
  logic                      in_tready;
  logic [cdq_pkg::IN_W-1:0]  in_tdata   = '0;
  logic                      out_tvalid;
  logic                      out_tready = 1'b0;
  logic [cdq_pkg::OUT_W-1:0] out_tdata;

  deque_scoreboard sb = new();

  int in_idle_pct  = 31;
  int out_idle_pct = 72;
  int words_sent   = 0;
  int level        = 0;
  int stall_cycles = 0;

  circular_deque_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= out_idle_pct);
  end

  // both channels sampled at the edge, before any update from that edge lands
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready)
        sb.note_word(in_tdata[2:0], in_tdata[34:3]);
      if (out_tvalid && out_tready)
        sb.check_word(out_tdata);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("tb_circular_deque_unit: FAIL");
        $finish;
      end
    end
  end

  task automatic send_word(input logic [cdq_pkg::CMD_W-1:0] cmd_bits,
                           input logic [cdq_pkg::VAL_W-1:0] value);
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {5'b0, value, cmd_bits};
    @(posedge clk);
    while (in_tready !== 1'b1) @(posedge clk);
    // track fill level so the random part knows when the ring is full
    case (cdq_pkg::cmd_t'(cmd_bits))
      cdq_pkg::CMD_PUSH_FRONT, cdq_pkg::CMD_PUSH_BACK: if (level < CAPACITY) level++;
      cdq_pkg::CMD_POP_FRONT, cdq_pkg::CMD_POP_BACK:   if (level > 0) level--;
      default: ;
    endcase
    words_sent++;
    if (words_sent == 500) begin
      in_idle_pct  = 72;
      out_idle_pct = 31;
    end else if (words_sent == 1000) begin
      in_idle_pct  = 0;
      out_idle_pct = 0;
    end
  endtask

  function automatic logic [cdq_pkg::VAL_W-1:0] pick_value();
    case ($urandom_range(19))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic random_word(input int push_pct);
    logic [cdq_pkg::CMD_W-1:0] c;
    if ($urandom_range(99) < 4) begin
      // query or an unused code
      c = cdq_pkg::CMD_QUERY + cdq_pkg::CMD_W'($urandom_range(3));
    end else if ($urandom_range(99) < push_pct) begin
      c = $urandom_range(1) ? cdq_pkg::CMD_PUSH_BACK : cdq_pkg::CMD_PUSH_FRONT;
    end else begin
      c = $urandom_range(1) ? cdq_pkg::CMD_POP_BACK : cdq_pkg::CMD_POP_FRONT;
    end
    send_word(c, pick_value());
  endtask

  initial begin
    int guard;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // empty deque: query and pops from both ends
    send_word(cdq_pkg::CMD_QUERY, $urandom);
    send_word(cdq_pkg::CMD_POP_FRONT, $urandom);
    send_word(cdq_pkg::CMD_POP_BACK, $urandom);
    // extreme values at both ends
    send_word(cdq_pkg::CMD_PUSH_BACK, 32'h7FFF_FFFF);
    send_word(cdq_pkg::CMD_PUSH_FRONT, 32'h8000_0000);
    send_word(cdq_pkg::CMD_PUSH_BACK, 32'h0000_0000);
    send_word(cdq_pkg::CMD_PUSH_FRONT, 32'hFFFF_FFFF);
    send_word(cdq_pkg::CMD_PUSH_BACK, 32'h0000_0001);
    send_word(cdq_pkg::CMD_QUERY, $urandom);
    send_word(cdq_pkg::CMD_QUERY + 3'd1, $urandom);
    send_word(cdq_pkg::CMD_QUERY + 3'd2, $urandom);
    send_word(cdq_pkg::CMD_QUERY + 3'd3, 32'hFFFF_FFFF);
    // drain through both ends down to empty and past it
    send_word(cdq_pkg::CMD_POP_FRONT, $urandom);
    send_word(cdq_pkg::CMD_POP_BACK, $urandom);
    send_word(cdq_pkg::CMD_POP_FRONT, $urandom);
    send_word(cdq_pkg::CMD_POP_BACK, $urandom);
    send_word(cdq_pkg::CMD_POP_BACK, $urandom);
    send_word(cdq_pkg::CMD_POP_FRONT, $urandom);
    // single item leaving by the opposite end
    send_word(cdq_pkg::CMD_PUSH_FRONT, $urandom);
    send_word(cdq_pkg::CMD_POP_BACK, $urandom);
    send_word(cdq_pkg::CMD_PUSH_BACK, $urandom);
    send_word(cdq_pkg::CMD_POP_FRONT, $urandom);

    // balanced traffic around empty, then fill to capacity
    repeat (150) random_word(50);
    guard = 0;
    while (level < CAPACITY && guard < 4000) begin
      random_word(97);
      guard++;
    end
    // churn while full, then drain
    repeat (40) random_word(60);
    repeat (200) random_word(15);

    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tb_circular_deque_unit: PASS");
    end else begin
      $display("tb_circular_deque_unit: FAIL");
    end
    $finish;
  end

endmodule
